/* hdl/cfp_pkg.sv */
package cfp_pkg;

  // default depth of the payload count
  localparam int unsigned BUFFER_BYTES_DEF = 16;

  // payload bytes that are kept for decoding
  localparam int unsigned HEAD_BYTES = 3;
  localparam int unsigned SENSOR_BITS = 24;

  // header and framing bytes
  localparam logic [7:0] HDR_LINE   = 8'h4C;  // 'L'
  localparam logic [7:0] HDR_GREEN  = 8'h47;  // 'G'
  localparam logic [7:0] HDR_SENSOR = 8'h53;  // 'S'
  localparam logic [7:0] BYTE_END   = 8'hFF;
  localparam logic [7:0] BYTE_MARK  = 8'h00;
  localparam logic [7:0] LAST_INIT  = 8'h01;

  // frame kind codes on the result channel
  localparam logic [1:0] FRAME_LINE   = 2'd0;
  localparam logic [1:0] FRAME_GREEN  = 2'd1;
  localparam logic [1:0] FRAME_SENSOR = 2'd2;

  typedef enum logic [1:0] {
    KIND_IDLE   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_GREEN  = 2'd2,
    KIND_SENSOR = 2'd3
  } rx_kind_t;

  typedef struct packed {
    logic [1:0]              frame_kind;
    logic                    short_frame;
    logic [7:0]              line_kind;
    logic signed [7:0]       line_angle_out;
    logic signed [7:0]       line_offset_out;
    logic [SENSOR_BITS-1:0]  sensor_bits_out;
    logic [2:0]              left_count;
    logic [2:0]              mid_count;
    logic [2:0]              right_count;
    logic [4:0]              total_count;
  } res_t;

endpackage

/* hdl/cfp_in_if.sv */
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/cfp_out_if.sv */
interface cfp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        frame_kind;
  logic              short_frame;
  logic [7:0]        line_kind;
  logic signed [7:0] line_angle_out;
  logic signed [7:0] line_offset_out;
  logic [23:0]       sensor_bits_out;
  logic [2:0]        left_count;
  logic [2:0]        mid_count;
  logic [2:0]        right_count;
  logic [4:0]        total_count;

  modport source (
    output valid, input ready, output frame_kind, output short_frame, output line_kind,
    output line_angle_out, output line_offset_out, output sensor_bits_out,
    output left_count, output mid_count, output right_count, output total_count
  );
  modport sink (
    input valid, output ready, input frame_kind, input short_frame, input line_kind,
    input line_angle_out, input line_offset_out, input sensor_bits_out,
    input left_count, input mid_count, input right_count, input total_count
  );
endinterface

/* hdl/cfp_in_reg.sv */
module cfp_in_reg
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       in_ready,
  output logic       byte_vld,
  output logic [7:0] byte_val
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // stage is free when empty or when its item moves on this cycle
  assign in_ready = !vld_r || advance;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

/* hdl/cfp_frame_core.sv */
module cfp_frame_core
  import cfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_val,
  output logic       res_vld,
  output res_t       res
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

  rx_kind_t               kind_r, kind_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [7:0]             last_r, last_nxt;
  logic [7:0]             head_r [HEAD_BYTES];
  logic [7:0]             head_nxt [HEAD_BYTES];
  logic [7:0]             lkind_r, lkind_nxt;
  logic [7:0]             angle_r, angle_nxt;
  logic [7:0]             offset_r, offset_nxt;
  logic [SENSOR_BITS-1:0] sens_r, sens_nxt;
  logic [SENSOR_BITS-1:0] sens_dec;
  logic [SENSOR_BITS-1:0] head_cat;
  logic                   end_hit;
  logic                   full;
  logic [2:0]             cnt_l, cnt_m, cnt_r;

  function automatic logic [2:0] ones7(input logic [6:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 7; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  // end of frame: 0xff right after a stored 0x00
  assign end_hit = (byte_val == BYTE_END) && (kind_r != KIND_IDLE) &&
                   (count_r != '0) && (last_r == BYTE_MARK);
  assign full    = count_r >= CNT_W'(HEAD_BYTES);

  // first payload byte, msb first, lands in flag 0; flags are active low
  assign head_cat = {head_r[0], head_r[1], head_r[2]};
  always_comb begin
    for (int i = 0; i < SENSOR_BITS; i++) begin
      sens_dec[i] = ~head_cat[SENSOR_BITS-1-i];
    end
  end

  // frame kind sequencing
  always_comb begin
    kind_nxt = kind_r;
    if (byte_vld) begin
      if (end_hit) begin
        kind_nxt = KIND_IDLE;
      end else if (kind_r == KIND_IDLE) begin
        case (byte_val)
          HDR_LINE:   kind_nxt = KIND_LINE;
          HDR_GREEN:  kind_nxt = KIND_GREEN;
          HDR_SENSOR: kind_nxt = KIND_SENSOR;
          default:    kind_nxt = KIND_IDLE;
        endcase
      end
    end
  end

  // payload capture, held values and result
  always_comb begin
    count_nxt  = count_r;
    last_nxt   = last_r;
    head_nxt   = head_r;
    lkind_nxt  = lkind_r;
    angle_nxt  = angle_r;
    offset_nxt = offset_r;
    sens_nxt   = sens_r;
    res_vld    = 1'b0;
    if (byte_vld) begin
      if (end_hit) begin
        res_vld   = 1'b1;
        count_nxt = '0;
        last_nxt  = LAST_INIT;
        if (full) begin
          unique case (kind_r)
            KIND_LINE: begin
              lkind_nxt  = head_r[0];
              angle_nxt  = head_r[1];
              offset_nxt = head_r[2];
            end
            KIND_SENSOR: sens_nxt = sens_dec;
            KIND_GREEN, KIND_IDLE: ;
          endcase
        end
      end else if (kind_r != KIND_IDLE) begin
        for (int i = 0; i < HEAD_BYTES; i++) begin
          if (count_r == CNT_W'(i)) begin
            head_nxt[i] = byte_val;
          end
        end
        if (count_r != CNT_W'(BUFFER_BYTES)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        last_nxt = byte_val;
      end
    end
  end

  assign cnt_l = ones7(sens_nxt[9:3]);
  assign cnt_m = ones7({1'b0, sens_nxt[15:10]});
  assign cnt_r = ones7(sens_nxt[22:16]);

  always_comb begin
    case (kind_r)
      KIND_LINE:  res.frame_kind = FRAME_LINE;
      KIND_GREEN: res.frame_kind = FRAME_GREEN;
      default:    res.frame_kind = FRAME_SENSOR;
    endcase
    res.short_frame     = !full;
    res.line_kind       = lkind_nxt;
    res.line_angle_out  = angle_nxt;
    res.line_offset_out = offset_nxt;
    res.sensor_bits_out = sens_nxt;
    res.left_count      = cnt_l;
    res.mid_count       = cnt_m;
    res.right_count     = cnt_r;
    res.total_count     = 5'(cnt_l) + 5'(cnt_m) + 5'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_IDLE;
      count_r  <= '0;
      last_r   <= LAST_INIT;
      lkind_r  <= '0;
      angle_r  <= '0;
      offset_r <= '0;
      sens_r   <= '0;
    end else begin
      kind_r   <= kind_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      lkind_r  <= lkind_nxt;
      angle_r  <= angle_nxt;
      offset_r <= offset_nxt;
      sens_r   <= sens_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

endmodule

/* hdl/cfp_out_reg.sv */
module cfp_out_reg
  import cfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic res_vld,
  input  res_t res,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_res
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = res_vld;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

/* hdl/camera_frame_parser_top.sv */
// camera frame parser
// in_ch carries one received serial byte per item (valid/ready, rx_byte).
// out_ch carries one decoded frame result per item: frame kind, short-frame
// flag, the held line type/angle/offset, the held 24 sensor flags and the
// left/mid/right/total counts of set flags.
// a byte is taken into an input register, then the frame tracker works on it
// once it moves on, and a finished frame is written to the result register.
// the result of a closing 0xff byte is loaded into the result register as that
// byte moves on from the input register, and is shown on out_ch from then on.
// throughput: one byte per cycle unless a waiting result stalls on out_ch.ready;
// bytes that end no frame produce no result item.
// reset (rst_n low, synchronous): frame tracker idle, payload count zero,
// held line and sensor values zero, both registers empty.
// stall: a waiting result holds the result register; the byte behind it
// waits in the input register, whether or not it ends a frame, and
// in_ch.ready drops only while both are full and out_ch.ready is low
module camera_frame_parser_top
  import cfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cfp_in_if.sink   in_ch,
  cfp_out_if.source out_ch
);

  logic       byte_vld;
  logic [7:0] byte_val;
  logic       advance;
  logic       res_vld;
  res_t       res;
  res_t       out_res;
  logic       out_valid;

  // the staged byte moves on when the result register is free or emptying
  assign advance = byte_vld && (!out_valid || out_ch.ready);

  cfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .advance  (advance),
    .in_ready (in_ch.ready),
    .byte_vld (byte_vld),
    .byte_val (byte_val)
  );

  cfp_frame_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (advance),
    .byte_val (byte_val),
    .res_vld  (res_vld),
    .res      (res)
  );

  cfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.frame_kind      = out_res.frame_kind;
  assign out_ch.short_frame     = out_res.short_frame;
  assign out_ch.line_kind       = out_res.line_kind;
  assign out_ch.line_angle_out  = out_res.line_angle_out;
  assign out_ch.line_offset_out = out_res.line_offset_out;
  assign out_ch.sensor_bits_out = out_res.sensor_bits_out;
  assign out_ch.left_count      = out_res.left_count;
  assign out_ch.mid_count       = out_res.mid_count;
  assign out_ch.right_count     = out_res.right_count;
  assign out_ch.total_count     = out_res.total_count;

  // a new result appears only after a staged byte moved on
  a_rise_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a processed byte");

  // input backpressure only when both registers are held
  a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (byte_vld && out_valid && !out_ch.ready))
    else $error("input stalled without a held result");

  // the total is the sum of the three zone counts
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.total_count ==
      5'(out_res.left_count) + 5'(out_res.mid_count) + 5'(out_res.right_count)))
    else $error("total count mismatch");

  // a short frame never changes the held sensor flags
  a_short_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_vld && res.short_frame && !(out_valid && !out_ch.ready) &&
     $past(rst_n) && $past(advance && res_vld))
    |-> (res.sensor_bits_out == $past(res.sensor_bits_out)))
    else $error("short frame changed sensor flags");

endmodule
